FILE: src/rgb_to_hsv_converter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB to HSV converter.
// All checks are clocked on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types, constants and the shared long-division step of the RGB to HSV
// converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Degrees per hue sector, and the offsets of the green and blue sectors.
    localparam logic [8:0] HUE_SECTOR_DEG = 9'd60;
    localparam logic [8:0] HUE_GREEN_OFS  = 9'd120;
    localparam logic [8:0] HUE_BLUE_OFS   = 9'd240;
    localparam logic [8:0] HUE_FULL_DEG   = 9'd360;
    localparam logic [7:0] FULL_SCALE     = 8'd255;

    // Both dividends are below 512 times their divisor, so nine quotient bits.
    localparam int DIV_STEPS = 9;

    // Input item: one RGB pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Result item: hue in degrees, saturation and value.
    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // One long-division lane: partial remainder, dividend bits still to
    // shift in, quotient bits so far, and the divisor.
    typedef struct packed {
        logic [7:0] divisor;
        logic [7:0] rem;
        logic [8:0] num;
        logic [8:0] quo;
    } div_lane_t;

    // Everything that travels through the divider pipeline.
    typedef struct packed {
        div_lane_t  hue_lane;
        div_lane_t  sat_lane;
        logic [7:0] brightness;
    } div_item_t;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor where it fits. The remainder stays below the
    // divisor, so the shifted value fits in nine bits.
    function automatic div_lane_t div_lane_step(input div_lane_t lane);
        div_lane_t  res;
        logic [8:0] trial;
        trial = {lane.rem, lane.num[8]};
        res = lane;
        res.num = {lane.num[7:0], 1'b0};
        if (trial >= {1'b0, lane.divisor}) begin
            res.rem = 8'(trial - {1'b0, lane.divisor});
            res.quo = {lane.quo[7:0], 1'b1};
        end else begin
            res.rem = trial[7:0];
            res.quo = {lane.quo[7:0], 1'b0};
        end
        return res;
    endfunction

endpackage

FILE: src/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Converts one 8-bit RGB pixel per item into hue, saturation and value.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    pixel_t: red, green, blue
//   m_       out        m_valid/m_ready    hsv_t: hue, saturation, brightness
//
// One item enters per cycle while s_ready is high. An item passes twelve
// registers: two front stages, nine divider stages (one quotient bit each)
// and the output register. The first is loaded at the accepting edge.
// Reset empties every stage. A stall at m_ready backs up stage by stage,
// so empty stages keep taking items until the pipe is full.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rhc_pkg::pixel_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rhc_pkg::hsv_t   m_data
);
    import rhc_pkg::*;

    div_item_t stage_data [DIV_STEPS + 1];
    logic      stage_valid [DIV_STEPS + 1];
    logic      stage_ready [DIV_STEPS + 1];

    hsv_t      out_next;
    hsv_t      out_reg;
    logic      out_valid_reg;

    // Range and dividend stages.
    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    // Divider pipeline, one quotient bit per stage.
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        rhc_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i + 1]),
            .out_ready (stage_ready[i + 1]),
            .out_data  (stage_data[i + 1])
        );
    end

    // A zero divisor means a gray or black pixel: hue and saturation are zero.
    always_comb begin
        out_next.brightness = stage_data[DIV_STEPS].brightness;
        if (stage_data[DIV_STEPS].hue_lane.divisor == '0) begin
            out_next.hue = '0;
        end else begin
            out_next.hue = stage_data[DIV_STEPS].hue_lane.quo;
        end
        if (stage_data[DIV_STEPS].sat_lane.divisor == '0) begin
            out_next.saturation = '0;
        end else begin
            out_next.saturation = stage_data[DIV_STEPS].sat_lane.quo[7:0];
        end
    end

    // Output register.
    assign stage_ready[DIV_STEPS] = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_ready[DIV_STEPS]) begin
            out_valid_reg <= stage_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_valid[DIV_STEPS] && stage_ready[DIV_STEPS]) out_reg <= out_next;
    end

    // Only a held result can stop the input side.
    `RHC_ASSERT_SAME(a_stall_from_output, !s_ready, m_valid && !m_ready, "input stalled without output stall")
    // Hue stays within one turn.
    `RHC_ASSERT_SAME(a_hue_range, m_valid, m_data.hue < HUE_FULL_DEG, "hue out of range")
    // A black pixel has no saturation and no hue.
    `RHC_ASSERT_SAME(a_black_pixel, m_valid && m_data.brightness == '0, m_data.saturation == '0 && m_data.hue == '0, "black pixel with hue or saturation")
    // Zero saturation only comes from a gray pixel, whose hue is zero.
    `RHC_ASSERT_SAME(a_gray_hue, m_valid && m_data.saturation == '0, m_data.hue == '0, "gray pixel with nonzero hue")
    // With the output free, a valid last divider stage yields a result next cycle.
    `RHC_ASSERT_NEXT(a_drain, stage_valid[DIV_STEPS] && stage_ready[DIV_STEPS], m_valid, "divider output lost")

endmodule

FILE: src/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Two pipeline stages ahead of the divider: find the largest and smallest
// channel and the hue sector, then build both dividends.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rhc_pkg::pixel_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rhc_pkg::div_item_t out_data
);
    import rhc_pkg::*;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [7:0]        mx;
        logic [7:0]        chroma;
        sector_t           sector;
        logic signed [8:0] diff;
    } range_t;

    range_t      a_next;
    range_t      a_reg;
    logic        a_valid_reg;
    logic        a_ready;
    div_item_t   b_next;
    div_item_t   b_reg;
    logic        b_valid_reg;

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [16:0]        offset;
    logic [16:0]        full_turn;
    logic signed [18:0] hue_sum;
    logic [16:0]        hue_num;
    logic [16:0]        sat_num;

    // Stage A: largest and smallest channel, sector and channel difference.
    always_comb begin
        mx = in_data.red;
        mn = in_data.red;
        if (in_data.green > mx) mx = in_data.green;
        if (in_data.blue > mx) mx = in_data.blue;
        if (in_data.green < mn) mn = in_data.green;
        if (in_data.blue < mn) mn = in_data.blue;
        a_next.mx = mx;
        a_next.chroma = mx - mn;
        // Red wins a tie for the largest channel, then green.
        if (in_data.red == mx) begin
            a_next.sector = SEC_RED;
            a_next.diff = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
        end else if (in_data.green == mx) begin
            a_next.sector = SEC_GREEN;
            a_next.diff = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
        end else begin
            a_next.sector = SEC_BLUE;
            a_next.diff = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
        end
    end

    // Stage B: hue times chroma, wrapped into one turn, and 255 times chroma.
    always_comb begin
        case (a_reg.sector)
            SEC_RED:   offset = '0;
            SEC_GREEN: offset = 17'(a_reg.chroma) * 17'(HUE_GREEN_OFS);
            SEC_BLUE:  offset = 17'(a_reg.chroma) * 17'(HUE_BLUE_OFS);
            default:   offset = '0;
        endcase
        full_turn = 17'(a_reg.chroma) * 17'(HUE_FULL_DEG);
        hue_sum = $signed({2'b00, offset})
                + 19'(a_reg.diff) * $signed({10'd0, HUE_SECTOR_DEG});
        if (hue_sum < 0) begin
            hue_sum = hue_sum + $signed({2'b00, full_turn});
        end
        hue_num = hue_sum[16:0];
        sat_num = 17'(a_reg.chroma) * 17'(FULL_SCALE);

        b_next.hue_lane.divisor = a_reg.chroma;
        b_next.hue_lane.rem     = hue_num[16:9];
        b_next.hue_lane.num     = hue_num[8:0];
        b_next.hue_lane.quo     = '0;
        b_next.sat_lane.divisor = a_reg.mx;
        b_next.sat_lane.rem     = sat_num[16:9];
        b_next.sat_lane.num     = sat_num[8:0];
        b_next.sat_lane.quo     = '0;
        b_next.brightness       = a_reg.mx;
    end

    // Each stage loads when it is empty or its content moves on.
    assign in_ready  = !a_valid_reg || a_ready;
    assign a_ready   = !b_valid_reg || out_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_ready) a_valid_reg <= in_valid;
            if (a_ready) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) a_reg <= a_next;
        if (a_valid_reg && a_ready) b_reg <= b_next;
    end

endmodule

FILE: src/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rhc_div_step
// One registered stage of the divider: produces one quotient bit of the hue
// and one of the saturation.
// ----------------------------------------------------------------------------
module rhc_div_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rhc_pkg::div_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rhc_pkg::div_item_t out_data
);
    import rhc_pkg::*;

    div_item_t data_next;
    div_item_t data_reg;
    logic      valid_reg;

    // Both lanes advance by one bit; brightness rides along.
    always_comb begin
        data_next.hue_lane   = div_lane_step(in_data.hue_lane);
        data_next.sat_lane   = div_lane_step(in_data.sat_lane);
        data_next.brightness = in_data.brightness;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) data_reg <= data_next;
    end

endmodule

FILE: sim/rgb_to_hsv_converter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit_tb
// Self-checking bench for the RGB to HSV converter. A queue of pixels, first
// corner cases and then random and biased pixels, feeds a clocked driver.
// Each accepted pixel is converted by an independent integer model into the
// expected hue, saturation and value. A clocked monitor compares every
// result, field by field, against the oldest expected one. Both sides idle
// at random, and the receiver holds off once for a long stretch so that the
// pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit_tb;

    import rhc_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RANDOM_PIXELS = 900;
    localparam int QUIET_FROM    = 400;
    localparam int QUIET_TO      = 600;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 24;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    pixel_t s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    hsv_t   m_data;

    pixel_t pixels_to_send[$];
    hsv_t   hsv_expected[$];

    int pixels_sent    = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int input_stalls   = 0;
    int gray_pixels    = 0;
    int wrapped_pixels = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    rgb_to_hsv_converter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // Expected hue, saturation and value of one pixel, in exact integers.
    function automatic hsv_t hsv_of(pixel_t px);
        int   r, g, b, mx, mn, chroma, num;
        hsv_t res;
        r  = int'(px.red);
        g  = int'(px.green);
        b  = int'(px.blue);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        chroma = mx - mn;
        res = '0;
        res.brightness = 8'(mx);
        if (mx > 0) res.saturation = 8'((int'(FULL_SCALE) * chroma) / mx);
        if (chroma > 0) begin
            // Red wins ties, then green; hue times chroma is kept exact.
            if (r == mx)
                num = int'(HUE_SECTOR_DEG) * (g - b);
            else if (g == mx)
                num = int'(HUE_GREEN_OFS) * chroma + int'(HUE_SECTOR_DEG) * (b - r);
            else
                num = int'(HUE_BLUE_OFS) * chroma + int'(HUE_SECTOR_DEG) * (r - g);
            if (num < 0) num += int'(HUE_FULL_DEG) * chroma;
            res.hue = 9'(num / chroma);
        end
        return res;
    endfunction

    // Random idle decision, switched off inside the quiet window.
    function automatic bit idle_draw(int count);
        return (count < QUIET_FROM || count >= QUIET_TO) && ($urandom_range(99) < 15);
    endfunction

    // Queue one pixel and note the special cases it exercises.
    task automatic add_pixel(int r, int g, int b);
        pixel_t px;
        px.red   = 8'(r);
        px.green = 8'(g);
        px.blue  = 8'(b);
        pixels_to_send.push_back(px);
        if (r == g && g == b) gray_pixels++;
        if (r >= g && r >= b && g < b) wrapped_pixels++;
    endtask

    // Stimulus, reset and end of run.
    initial begin
        int v, lo, which, top;
        // Black, white and gray pixels.
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(128, 128, 128);
        add_pixel(1, 1, 1);
        // Pure primaries and secondaries, including ties for the maximum.
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        // Red largest with green below blue, so the hue wraps.
        add_pixel(255, 0, 1);
        add_pixel(255, 0, 254);
        add_pixel(200, 10, 100);
        // Small chroma, small maximum and ordinary mixtures.
        add_pixel(1, 0, 0);
        add_pixel(0, 1, 0);
        add_pixel(0, 0, 1);
        add_pixel(255, 254, 0);
        add_pixel(0, 1, 255);
        add_pixel(200, 100, 50);
        add_pixel(10, 20, 30);
        add_pixel(170, 85, 255);
        add_pixel(254, 255, 253);

        // Random part, biased toward gray, ties, small chroma and wrapping hue.
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            which = $urandom_range(99);
            if (which < 10) begin
                v = $urandom_range(255);
                add_pixel(v, v, v);
            end else if (which < 25) begin
                top = $urandom_range(1, 255);
                lo  = $urandom_range(0, top);
                case ($urandom_range(2))
                    0:       add_pixel(top, top, lo);
                    1:       add_pixel(lo, top, top);
                    default: add_pixel(top, lo, top);
                endcase
            end else if (which < 40) begin
                v = $urandom_range(2, 253);
                add_pixel(v + int'($urandom_range(2)) - 1, v + int'($urandom_range(2)) - 1,
                          v + int'($urandom_range(2)) - 1);
            end else if (which < 55) begin
                top = $urandom_range(2, 255);
                v   = $urandom_range(1, top - 1);
                lo  = $urandom_range(0, v - 1);
                add_pixel(top, lo, v);
            end else begin
                add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pixels_to_send.size() != 0 || s_valid) @(posedge aclk);
        while (hsv_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (hsv_expected.size() != 0) mismatches++;

        $display("Converted %0d pixels (%0d gray, %0d with wrapped hue), checked %0d results.",
                 pixels_sent, gray_pixels, wrapped_pixels, results_seen);
        $display("Input was held off for %0d cycles; %0d mismatches.", input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("rgb_to_hsv_converter_unit_tb passed");
        end else begin
            $display("rgb_to_hsv_converter_unit_tb failed");
        end
        $finish;
    end

    // Driver: offers the next pixel and records its expected result on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hsv_expected.push_back(hsv_of(s_data));
                pixels_sent <= pixels_sent + 1;
            end
            if (s_valid && !s_ready) input_stalls <= input_stalls + 1;
            if (!s_valid || s_ready) begin
                if (pixels_to_send.size() != 0 && !idle_draw(pixels_sent)) begin
                    s_valid <= 1'b1;
                    s_data  <= pixels_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with one long hold-off that backs up the pipeline.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !idle_draw(results_seen);
        end
    end

    // Monitor: compares each accepted result with the oldest expected one.
    always @(posedge aclk) begin
        hsv_t want;
        int   bad;
        bad = 0;
        if (aresetn && m_valid && m_ready) begin
            if (hsv_expected.size() == 0) begin
                $display("%t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                         m_data.hue, m_data.saturation, m_data.brightness);
                bad = 1;
            end else begin
                want = hsv_expected.pop_front();
                if (m_data.hue != want.hue) begin
                    $display("%t: hue expected %0d, got %0d", $time, want.hue, m_data.hue);
                    bad++;
                end
                if (m_data.saturation != want.saturation) begin
                    $display("%t: saturation expected %0d, got %0d", $time,
                             want.saturation, m_data.saturation);
                    bad++;
                end
                if (m_data.brightness != want.brightness) begin
                    $display("%t: brightness expected %0d, got %0d", $time,
                             want.brightness, m_data.brightness);
                    bad++;
                end
            end
            results_seen <= results_seen + 1;
            if (bad != 0) mismatches <= mismatches + 1;
        end
    end

    // Timeout guard.
    initial begin
        #2_000_000;
        $display("rgb_to_hsv_converter_unit_tb failed");
        $finish;
    end

endmodule
